>>> rtl/core/bmlc_pkg.sv
`timescale 1ns / 1ps

package bmlc_pkg;

	localparam int unsigned REQ_W  = 3;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned IDX_W  = 6;
	localparam int unsigned COL_W  = 3;
	localparam int unsigned COLS   = 8;

	localparam logic [BYTE_W-1:0] HOLDOFF_RESET = 8'd100;

	typedef enum logic [REQ_W-1:0] {
		REQ_TICK    = 3'd0,
		REQ_MODE_WR = 3'd1,
		REQ_LED_WR  = 3'd2,
		REQ_LED_CLR = 3'd3,
		REQ_LED_RD  = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		ACT_NONE    = 2'd0,
		ACT_TOGGLE  = 2'd1,
		ACT_RADIO   = 2'd2,
		ACT_IMPULSE = 2'd3
	} act_t;

	typedef struct packed {
		logic accept;
		logic ho_issue;
		logic col_issue;
		logic col_act;
		logic col_next;
		logic rad_issue;
		logic out_fetch;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic is_tick;
		logic idx_last;
		logic col_last;
		logic col_hit;
		logic radio_go;
		logic out_free;
	} sts_t;

endpackage

>>> rtl/core/bmlc_req_if.sv
`timescale 1ns / 1ps

interface bmlc_req_if;
	logic                              valid;
	logic                              ready;
	logic [bmlc_pkg::REQ_W-1:0]        req_type;
	logic [bmlc_pkg::BYTE_W-1:0]       switch_row;
	logic [bmlc_pkg::IDX_W-1:0]        entry_index;
	logic [bmlc_pkg::BYTE_W-1:0]       entry_value;

	modport source (output valid, req_type, switch_row, entry_index, entry_value, input ready);
	modport sink (input valid, req_type, switch_row, entry_index, entry_value, output ready);
endinterface

>>> rtl/core/bmlc_rsp_if.sv
`timescale 1ns / 1ps

interface bmlc_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [bmlc_pkg::COL_W-1:0]        drive_row;
	logic [bmlc_pkg::BYTE_W-1:0]       drive_pattern;
	logic [bmlc_pkg::BYTE_W-1:0]       read_value;

	modport source (output valid, drive_row, drive_pattern, read_value, input ready);
	modport sink (input valid, drive_row, drive_pattern, read_value, output ready);
endinterface

>>> rtl/core/button_matrix_latch_controller_top.sv
`timescale 1ns / 1ps

// Button pad controller for a ROWS x 8 key matrix with one LED per key.
// req channel: one beat per request (scan tick, mode write, LED row write,
// LED clear, LED row read). rsp channel: exactly one beat per request,
// carrying the selected row, its LED byte and the read data.
// cfg_wr_en / cfg_wr_data load the toggle holdoff (ticks).
// A host request goes from accept through the fetch and load states, and the
// load waits until the output register is free; requests are taken in idle.
// A scan tick makes one pass over the holdoff memory (one entry a cycle),
// then visits each column of the row, with one more step for a column with an
// edge, and for each radio press walks the mode memory one entry a cycle.
// The mode, holdoff and LED stores share one read port each among these
// passes, which sets the tick length; the LED store has a second read port
// for the read data of a request.
// Reset clears the row pointer, switch history, valid bits of all stores
// (modes, holdoffs and LEDs read as zero) and loads the holdoff of 100.
// A finished result waits in the output register; the next request is
// taken meanwhile, and its result holds until rsp is ready.
module button_matrix_latch_controller_top #(
	parameter int unsigned ROWS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [bmlc_pkg::BYTE_W-1:0]  cfg_wr_data,
	bmlc_req_if.sink                     req,
	bmlc_rsp_if.source                   rsp
);

	bmlc_pkg::cmd_t cmd;
	bmlc_pkg::sts_t sts;
	logic           in_ready;

	assign req.ready = in_ready;

	bmlc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bmlc_datapath #(
		.ROWS (ROWS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req_type    (req.req_type),
		.switch_row  (req.switch_row),
		.entry_index (req.entry_index),
		.entry_value (req.entry_value),
		.rsp         (rsp),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

>>> rtl/core/bmlc_ctrl.sv
`timescale 1ns / 1ps

module bmlc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  bmlc_pkg::sts_t  sts,
	output bmlc_pkg::cmd_t  cmd
);

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_HOLD    = 8'b0000_0010,
		ST_COL_RD  = 8'b0000_0100,
		ST_COL_ACT = 8'b0000_1000,
		ST_RADIO   = 8'b0001_0000,
		ST_RAD_END = 8'b0010_0000,
		ST_FETCH   = 8'b0100_0000,
		ST_LOAD    = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		in_ready  = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = sts.is_tick ? ST_HOLD : ST_FETCH;
				end
			end
			ST_HOLD: begin
				cmd.ho_issue = 1'b1;
				if (sts.idx_last) begin
					state_nxt = ST_COL_RD;
				end
			end
			ST_COL_RD: begin
				if (sts.col_hit) begin
					cmd.col_issue = 1'b1;
					state_nxt     = ST_COL_ACT;
				end else begin
					cmd.col_next = 1'b1;
					if (sts.col_last) begin
						state_nxt = ST_FETCH;
					end
				end
			end
			ST_COL_ACT: begin
				cmd.col_act = 1'b1;
				if (sts.radio_go) begin
					state_nxt = ST_RADIO;
				end else begin
					cmd.col_next = 1'b1;
					state_nxt    = sts.col_last ? ST_FETCH : ST_COL_RD;
				end
			end
			ST_RADIO: begin
				cmd.rad_issue = 1'b1;
				if (sts.idx_last) begin
					state_nxt = ST_RAD_END;
				end
			end
			ST_RAD_END: begin
				cmd.col_next = 1'b1;
				state_nxt    = sts.col_last ? ST_FETCH : ST_COL_RD;
			end
			ST_FETCH: begin
				cmd.out_fetch = 1'b1;
				state_nxt     = ST_LOAD;
			end
			ST_LOAD: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q != ST_IDLE))
		else $error("controller stayed idle after a request beat");

	a_act_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COL_ACT) |-> ($past(state_q) == ST_COL_RD))
		else $error("column action without a column read");

endmodule

>>> rtl/core/bmlc_datapath.sv
`timescale 1ns / 1ps

module bmlc_datapath #(
	parameter int unsigned ROWS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [bmlc_pkg::BYTE_W-1:0]   cfg_wr_data,
	input  logic [bmlc_pkg::REQ_W-1:0]    req_type,
	input  logic [bmlc_pkg::BYTE_W-1:0]   switch_row,
	input  logic [bmlc_pkg::IDX_W-1:0]    entry_index,
	input  logic [bmlc_pkg::BYTE_W-1:0]   entry_value,
	bmlc_rsp_if.source                    rsp,
	input  bmlc_pkg::cmd_t                cmd,
	output bmlc_pkg::sts_t                sts
);

	localparam int unsigned RW   = $clog2(ROWS);
	localparam int unsigned COLW = bmlc_pkg::COL_W;
	localparam int unsigned BW   = RW + COLW;
	localparam int unsigned NBTN = ROWS * bmlc_pkg::COLS;
	localparam int unsigned DW   = bmlc_pkg::BYTE_W;

	logic [DW-1:0]     cfg_q;
	logic [RW-1:0]     scan_row_q;
	logic [DW-1:0]     sw_q [ROWS];
	logic [DW-1:0]     rise_q;
	logic [DW-1:0]     fall_q;
	logic [bmlc_pkg::REQ_W-1:0] req_q;
	logic [2:0]        lrow_q;
	logic [BW-1:0]     idx_q;
	logic [COLW-1:0]   col_q;
	logic [DW-1:0]     mask_q;
	logic [DW-1:0]     radio_mode_q;

	logic [DW-1:0]     mode_mem [NBTN];
	logic [NBTN-1:0]   mode_vld_q;
	logic [DW-1:0]     md_q;
	logic              mv_q;

	logic [DW-1:0]     ho_mem [NBTN];
	logic [NBTN-1:0]   ho_vld_q;
	logic [DW-1:0]     hd_q;
	logic              hv_q;
	logic              ho_wb_s1;
	logic [BW-1:0]     ho_wa_s1;

	logic [DW-1:0]     led_mem [ROWS];
	logic [ROWS-1:0]   led_vld_q;
	logic [DW-1:0]     la_q;
	logic              lav_q;
	logic [DW-1:0]     lb_q;
	logic              lbv_q;

	logic              rad_v_s1;
	logic [BW-1:0]     rad_idx_s1;

	logic              out_valid_q;
	logic [COLW-1:0]   out_row_q;
	logic [DW-1:0]     out_pat_q;
	logic [DW-1:0]     out_rd_q;

	logic [RW-1:0]     scan_nxt;
	logic [BW-1:0]     btn_addr;
	logic [DW-1:0]     edge_q;
	logic [DW-1:0]     mode_eff;
	logic [DW-1:0]     ho_eff;
	logic [DW-1:0]     led_a_eff;
	logic [DW-1:0]     led_b_eff;
	logic [DW-1:0]     col_bit;
	logic              rise_c;
	logic              fall_c;
	bmlc_pkg::act_t    act;
	logic              acc_tick;
	logic              acc_mode;
	logic              acc_led;
	logic              acc_clr;
	logic              tog_fire;
	logic              imp_we;
	logic [COLW-1:0]   rad_col;
	logic [RW-1:0]     rad_row;
	logic              rad_hit;
	logic [DW-1:0]     mask_nxt;
	logic              rad_we;
	logic              led_we;
	logic [RW-1:0]     led_wa;
	logic [DW-1:0]     led_wd;
	logic              led_ra_en;
	logic [RW-1:0]     led_ra;
	logic [RW-1:0]     led_rb;
	logic              ho_we;
	logic [BW-1:0]     ho_wa;
	logic [DW-1:0]     ho_wd;
	logic              ho_re;
	logic [BW-1:0]     ho_ra;
	logic              mode_re;
	logic [BW-1:0]     mode_ra;
	logic              idx_last;
	logic              col_last;

	assign scan_nxt  = (scan_row_q == RW'(ROWS - 1)) ? '0 : scan_row_q + RW'(1);
	assign btn_addr  = {scan_row_q, col_q};
	assign edge_q    = rise_q | fall_q;
	assign mode_eff  = mv_q ? md_q : '0;
	assign ho_eff    = hv_q ? hd_q : '0;
	assign led_a_eff = lav_q ? la_q : '0;
	assign led_b_eff = lbv_q ? lb_q : '0;
	assign col_bit   = 8'h80 >> col_q;
	assign rise_c    = rise_q[col_q];
	assign fall_c    = fall_q[col_q];
	assign act       = bmlc_pkg::act_t'(mode_eff[DW-1:DW-2]);

	assign acc_tick = cmd.accept && (req_type == bmlc_pkg::REQ_TICK);
	assign acc_mode = cmd.accept && (req_type == bmlc_pkg::REQ_MODE_WR)
		&& (32'(entry_index) < NBTN);
	assign acc_led  = cmd.accept && (req_type == bmlc_pkg::REQ_LED_WR)
		&& (32'(entry_index[2:0]) < ROWS);
	assign acc_clr  = cmd.accept && (req_type == bmlc_pkg::REQ_LED_CLR);

	assign tog_fire = cmd.col_act && (act == bmlc_pkg::ACT_TOGGLE) && rise_c
		&& (ho_eff == '0);
	assign imp_we   = cmd.col_act && (act == bmlc_pkg::ACT_IMPULSE) && (rise_c || fall_c);

	assign rad_col  = rad_idx_s1[COLW-1:0];
	assign rad_row  = rad_idx_s1[BW-1:COLW];
	assign rad_hit  = rad_v_s1 && (mode_eff == radio_mode_q);
	assign mask_nxt = mask_q | (rad_hit ? (8'h80 >> rad_col) : '0);
	assign rad_we   = rad_v_s1 && (rad_col == COLW'(bmlc_pkg::COLS - 1));

	assign idx_last = (idx_q == BW'(NBTN - 1));
	assign col_last = (col_q == COLW'(bmlc_pkg::COLS - 1));

	always_comb begin
		led_we = 1'b0;
		led_wa = scan_row_q;
		led_wd = led_a_eff;
		priority if (acc_led) begin
			led_we = 1'b1;
			led_wa = RW'(entry_index[2:0]);
			led_wd = entry_value;
		end else if (tog_fire) begin
			led_we = 1'b1;
			led_wd = led_a_eff ^ col_bit;
		end else if (imp_we) begin
			led_we = 1'b1;
			led_wd = rise_c ? (led_a_eff | col_bit) : (led_a_eff & ~col_bit);
		end else if (rad_we) begin
			led_we = 1'b1;
			led_wa = rad_row;
			led_wd = (led_a_eff & ~mask_nxt) | ((rad_row == scan_row_q) ? col_bit : '0);
		end
	end

	assign led_ra_en = cmd.col_issue || cmd.rad_issue || cmd.out_fetch;
	assign led_ra    = cmd.rad_issue ? idx_q[BW-1:COLW] : scan_row_q;
	assign led_rb    = RW'(lrow_q);

	always_comb begin
		ho_we = 1'b0;
		ho_wa = btn_addr;
		ho_wd = cfg_q;
		priority if (ho_wb_s1) begin
			ho_we = 1'b1;
			ho_wa = ho_wa_s1;
			ho_wd = ho_eff - DW'(ho_eff != '0);
		end else if (tog_fire) begin
			ho_we = 1'b1;
		end
	end

	assign ho_re   = cmd.ho_issue || cmd.col_issue;
	assign ho_ra   = cmd.ho_issue ? idx_q : btn_addr;
	assign mode_re = cmd.col_issue || cmd.rad_issue;
	assign mode_ra = cmd.rad_issue ? idx_q : btn_addr;

	always_comb begin
		sts          = '0;
		sts.is_tick  = (req_type == bmlc_pkg::REQ_TICK);
		sts.idx_last = idx_last;
		sts.col_last = col_last;
		sts.col_hit  = edge_q[col_q];
		sts.radio_go = (act == bmlc_pkg::ACT_RADIO) && rise_c;
		sts.out_free = !out_valid_q || rsp.ready;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q      <= bmlc_pkg::HOLDOFF_RESET;
			scan_row_q <= '0;
			for (int i = 0; i < ROWS; i++) begin
				sw_q[i] <= '0;
			end
			rise_q     <= '0;
			fall_q     <= '0;
			idx_q      <= '0;
			col_q      <= '0;
			mask_q     <= '0;
			mode_vld_q <= '0;
			ho_vld_q   <= '0;
			led_vld_q  <= '0;
			ho_wb_s1   <= 1'b0;
			rad_v_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cfg_q <= cfg_wr_data;
			end
			if (acc_tick) begin
				scan_row_q     <= scan_nxt;
				sw_q[scan_nxt] <= switch_row;
				rise_q         <= ~sw_q[scan_nxt] & switch_row;
				fall_q         <= sw_q[scan_nxt] & ~switch_row;
			end
			if (cmd.ho_issue || cmd.rad_issue) begin
				idx_q <= idx_last ? '0 : idx_q + BW'(1);
			end
			if (cmd.col_next) begin
				col_q <= col_last ? '0 : col_q + COLW'(1);
			end
			if (rad_we) begin
				mask_q <= '0;
			end else if (rad_v_s1) begin
				mask_q <= mask_nxt;
			end
			if (acc_mode) begin
				mode_vld_q[BW'(entry_index)] <= 1'b1;
			end
			if (ho_we) begin
				ho_vld_q[ho_wa] <= 1'b1;
			end
			if (acc_clr) begin
				led_vld_q <= '0;
			end else if (led_we) begin
				led_vld_q[led_wa] <= 1'b1;
			end
			ho_wb_s1 <= cmd.ho_issue;
			rad_v_s1 <= cmd.rad_issue;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q  <= req_type;
			lrow_q <= entry_index[2:0];
		end
		if (cmd.col_act) begin
			radio_mode_q <= mode_eff;
		end
		ho_wa_s1   <= idx_q;
		rad_idx_s1 <= idx_q;
		if (mode_re) begin
			mv_q <= mode_vld_q[mode_ra];
		end
		if (ho_re) begin
			hv_q <= ho_vld_q[ho_ra];
		end
		if (led_ra_en) begin
			lav_q <= led_vld_q[led_ra];
		end
		if (cmd.out_fetch) begin
			lbv_q <= led_vld_q[led_rb];
		end
		if (cmd.out_load) begin
			out_row_q <= COLW'(scan_row_q);
			out_pat_q <= led_a_eff;
			out_rd_q  <= ((req_q == bmlc_pkg::REQ_LED_RD) && (32'(lrow_q) < ROWS))
				? led_b_eff : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_mode) begin
			mode_mem[BW'(entry_index)] <= entry_value;
		end
		if (mode_re) begin
			md_q <= mode_mem[mode_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (ho_we) begin
			ho_mem[ho_wa] <= ho_wd;
		end
		if (ho_re) begin
			hd_q <= ho_mem[ho_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (led_we) begin
			led_mem[led_wa] <= led_wd;
		end
		if (led_ra_en) begin
			la_q <= led_mem[led_ra];
		end
		if (cmd.out_fetch) begin
			lb_q <= led_mem[led_rb];
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.drive_row     = out_row_q;
	assign rsp.drive_pattern = out_pat_q;
	assign rsp.read_value    = out_rd_q;

	a_led_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({acc_led, tog_fire, imp_we, rad_we}))
		else $error("LED row written from two sources in one cycle");

	a_holdoff_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(ho_wb_s1 && tog_fire))
		else $error("holdoff countdown collides with toggle reload");

	a_row_moves_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_row_q != $past(scan_row_q)) |-> $past(acc_tick))
		else $error("scan row moved without a scan tick");

endmodule
